/* hdl/tclp_pkg.sv */
// Shared types and constants for the text command line parser.
// No dependencies; the framer, queue, parser and top level refer to it by scoped names.
package tclp_pkg;

    // Special bytes of the framing and parsing
    localparam logic [7:0] C_NUL   = 8'h00;
    localparam logic [7:0] C_LF    = 8'h0A;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [7:0] C_COMMA = 8'h2C;
    localparam logic [7:0] C_ZERO  = 8'h30;
    localparam logic [7:0] C_NINE  = 8'h39;

    // Result frame kinds
    localparam logic [2:0] KIND_CMD   = 3'd0;
    localparam logic [2:0] KIND_SERVO = 3'd1;
    localparam logic [2:0] KIND_DIAG  = 3'd2;
    localparam logic [2:0] KIND_BAD   = 3'd3;
    localparam logic [2:0] KIND_LONG  = 3'd4;

    // Servo channel codes and angle limits
    localparam logic [1:0]  CHAN_G      = 2'd0;
    localparam logic [1:0]  CHAN_T      = 2'd1;
    localparam logic [1:0]  CHAN_B      = 2'd2;
    localparam logic [11:0] ANGLE_MAX_B = 12'd360;
    localparam logic [11:0] ANGLE_MAX   = 12'd270;

    // Input item on the byte channel
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_item;

    // Result item on the frame channel
    typedef struct packed {
        logic [2:0]  frame_kind;
        logic [31:0] seq_number;
        logic [3:0]  command_code;
        logic [1:0]  servo_channel;
        logic [8:0]  servo_angle;
    } t_result;

    // Token passed from the framer to the parser
    typedef enum logic [1:0] {
        TK_CHAR,    // content byte
        TK_FIN,     // NUL: end of content
        TK_END,     // newline of a kept line
        TK_LONG     // newline of a dropped line
    } t_tok_kind;

    typedef struct packed {
        t_tok_kind  kind;
        logic       cr_before;  // a held carriage return precedes this byte
        logic [7:0] value;
    } t_token;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Parser phases
    typedef enum logic [4:0] {
        PH_START,
        PH_C_M, PH_C_D, PH_C_COMMA,
        PH_S_E, PH_S_R, PH_S_V, PH_S_O, PH_S_COMMA,
        PH_D_I, PH_D_A, PH_D_G, PH_D_COMMA,
        PH_SEQ0_CMD, PH_SEQ0_SRV, PH_SEQ0_DIAG,
        PH_SEQ_CMD, PH_SEQ_SRV, PH_SEQ_DIAG,
        PH_LETTER, PH_CMD_END,
        PH_CHAN, PH_CHAN_COMMA,
        PH_ANG0, PH_ANG,
        PH_DONE_CMD, PH_DONE_SRV, PH_DONE_DIAG
    } t_phase;

endpackage

/* hdl/tclp_stream_if.sv */
// Valid/ready stream interface used for the byte and result channels.
// Payload type is a parameter; depends on nothing else.
interface tclp_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/tclp_front.sv */
// Framer: accepts received bytes, tracks line length, drop and carriage return.
// Emits parser tokens into the queue. Depends on tclp_pkg and tclp_stream_if.
module tclp_front #(
    parameter int MAX_LINE = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tclp_stream_if.sink         i_rx,
    input  tclp_pkg::t_q_status i_status,
    output logic                o_push,
    output tclp_pkg::t_token    o_token
);
    localparam int LEN_W = $clog2(MAX_LINE + 1);

    logic [LEN_W-1:0] r_len, n_len;
    logic             r_drop, n_drop;
    logic             r_cr, n_cr;
    logic             accept;
    logic [7:0]       c;

    // Take a byte whenever the queue has room
    assign i_rx.ready = !i_status.full;
    assign accept     = i_rx.valid && !i_status.full;
    assign c          = i_rx.data.rx_byte;

    // Classify the byte and update framing state
    always_comb begin
        n_len   = r_len;
        n_drop  = r_drop;
        n_cr    = r_cr;
        o_push  = 1'b0;
        o_token.kind      = tclp_pkg::TK_CHAR;
        o_token.cr_before = r_cr && (c != tclp_pkg::C_CR);
        o_token.value     = c;
        if (accept) begin
            if (c == tclp_pkg::C_LF) begin
                o_push       = 1'b1;
                o_token.kind = r_drop ? tclp_pkg::TK_LONG : tclp_pkg::TK_END;
                n_len        = '0;
                n_drop       = 1'b0;
                n_cr         = 1'b0;
            end else if (!r_drop) begin
                if (r_len >= LEN_W'(MAX_LINE)) begin
                    n_drop = 1'b1;
                end else begin
                    n_len = r_len + LEN_W'(1);
                    n_cr  = (c == tclp_pkg::C_CR);
                    if (c == tclp_pkg::C_CR) begin
                        // only a held carriage return becomes content
                        o_push = r_cr;
                    end else begin
                        o_push = 1'b1;
                        if (c == tclp_pkg::C_NUL) begin
                            o_token.kind = tclp_pkg::TK_FIN;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_drop <= 1'b0;
            r_cr   <= 1'b0;
        end else begin
            r_len  <= n_len;
            r_drop <= n_drop;
            r_cr   <= n_cr;
        end
    end

endmodule

/* hdl/tclp_queue.sv */
// Short token queue between the framer and the parser.
// Register array with read and write pointers. Depends on tclp_pkg.
module tclp_queue #(
    parameter int DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tclp_pkg::t_token    i_token,
    input  logic                i_pop,
    output tclp_pkg::t_token    o_token,
    output tclp_pkg::t_q_status o_status
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tclp_pkg::t_token r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_token         = r_mem[r_rd];
    assign o_status.empty  = (r_count == '0);
    assign o_status.full   = (r_count == CNT_W'(DEPTH));

    // Store the pushed token
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("pop from empty queue");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |-> r_count != CNT_W'(DEPTH))
        else $error("push into full queue");

endmodule

/* hdl/tclp_back.sv */
// Parser: consumes tokens, tracks the frame grammar and builds the result item.
// Holds the output register. Depends on tclp_pkg and tclp_stream_if.
module tclp_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tclp_pkg::t_token    i_token,
    input  tclp_pkg::t_q_status i_status,
    output logic                o_pop,
    tclp_stream_if.source       o_res
);
    tclp_pkg::t_phase  r_phase, n_phase;
    logic              r_err, n_err;
    logic [31:0]       r_seq, n_seq;
    logic [8:0]        r_ang, n_ang;
    logic [3:0]        r_dir, n_dir;
    logic [1:0]        r_chan, n_chan;
    logic              r_out_valid;
    tclp_pkg::t_result r_res, n_res;

    logic        line_end;
    logic        slot_free;
    logic        active;
    logic        digit;
    logic [3:0]  d;
    logic [35:0] seq_next;
    logic [11:0] ang_next;
    logic [11:0] ang_limit;
    logic [4:0]  dir_hit;
    logic [2:0]  chan_hit;
    logic [7:0]  c;

    // Direction letter to {hit, code}
    function automatic logic [4:0] dir_lookup(input logic [7:0] ch);
        logic [4:0] r;
        unique case (ch)
            "F":     r = {1'b1, 4'd0};
            "B":     r = {1'b1, 4'd1};
            "L":     r = {1'b1, 4'd2};
            "R":     r = {1'b1, 4'd3};
            "S":     r = {1'b1, 4'd4};
            "U":     r = {1'b1, 4'd5};
            "D":     r = {1'b1, 4'd6};
            "H":     r = {1'b1, 4'd7};
            "E":     r = {1'b1, 4'd8};
            "C":     r = {1'b1, 4'd9};
            "Q":     r = {1'b1, 4'd10};
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    // Servo channel letter to {hit, code}
    function automatic logic [2:0] chan_lookup(input logic [7:0] ch);
        logic [2:0] r;
        unique case (ch)
            "G":     r = {1'b1, tclp_pkg::CHAN_G};
            "T":     r = {1'b1, tclp_pkg::CHAN_T};
            "B":     r = {1'b1, tclp_pkg::CHAN_B};
            default: r = 3'd0;
        endcase
        return r;
    endfunction

    assign c         = i_token.value;
    assign line_end  = (i_token.kind == tclp_pkg::TK_END) ||
                       (i_token.kind == tclp_pkg::TK_LONG);
    assign slot_free = !r_out_valid || o_res.ready;
    assign o_pop     = !i_status.empty && (!line_end || slot_free);

    assign digit     = (c >= tclp_pkg::C_ZERO) && (c <= tclp_pkg::C_NINE);
    assign d         = digit ? 4'(c - tclp_pkg::C_ZERO) : 4'd0;
    assign seq_next  = ({4'd0, r_seq} << 3) + ({4'd0, r_seq} << 1) + 36'(d);
    assign ang_next  = ({3'd0, r_ang} << 3) + ({3'd0, r_ang} << 1) + 12'(d);
    assign ang_limit = (r_chan == tclp_pkg::CHAN_B) ? tclp_pkg::ANGLE_MAX_B
                                                    : tclp_pkg::ANGLE_MAX;
    assign dir_hit   = dir_lookup(c);
    assign chan_hit  = chan_lookup(c);
    assign active    = !r_err && (r_phase < tclp_pkg::PH_DONE_CMD);

    // Next phase and accumulators
    always_comb begin
        n_phase = r_phase;
        n_err   = r_err;
        n_seq   = r_seq;
        n_ang   = r_ang;
        n_dir   = r_dir;
        n_chan  = r_chan;
        if (o_pop) begin
            unique case (i_token.kind)
                tclp_pkg::TK_END, tclp_pkg::TK_LONG: begin
                    n_phase = tclp_pkg::PH_START;
                    n_err   = 1'b0;
                    n_seq   = '0;
                    n_ang   = '0;
                    n_dir   = '0;
                    n_chan  = '0;
                end
                tclp_pkg::TK_FIN: begin
                    if (active) begin
                        if (i_token.cr_before) begin
                            n_err = 1'b1;
                        end else begin
                            unique case (r_phase)
                                tclp_pkg::PH_CMD_END:  n_phase = tclp_pkg::PH_DONE_CMD;
                                tclp_pkg::PH_ANG:      n_phase = tclp_pkg::PH_DONE_SRV;
                                tclp_pkg::PH_SEQ_DIAG: n_phase = tclp_pkg::PH_DONE_DIAG;
                                default:               n_err   = 1'b1;
                            endcase
                        end
                    end
                end
                tclp_pkg::TK_CHAR: begin
                    if (active) begin
                        if (i_token.cr_before) begin
                            n_err = 1'b1;
                        end else begin
                            unique case (r_phase)
                                tclp_pkg::PH_START: begin
                                    if (c == "C") begin
                                        n_phase = tclp_pkg::PH_C_M;
                                    end else if (c == "S") begin
                                        n_phase = tclp_pkg::PH_S_E;
                                    end else if (c == "D") begin
                                        n_phase = tclp_pkg::PH_D_I;
                                    end else begin
                                        n_err = 1'b1;
                                    end
                                end
                                tclp_pkg::PH_C_M: begin
                                    if (c == "M") n_phase = tclp_pkg::PH_C_D;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_C_D: begin
                                    if (c == "D") n_phase = tclp_pkg::PH_C_COMMA;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_C_COMMA: begin
                                    if (c == tclp_pkg::C_COMMA) n_phase = tclp_pkg::PH_SEQ0_CMD;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_S_E: begin
                                    if (c == "E") n_phase = tclp_pkg::PH_S_R;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_S_R: begin
                                    if (c == "R") n_phase = tclp_pkg::PH_S_V;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_S_V: begin
                                    if (c == "V") n_phase = tclp_pkg::PH_S_O;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_S_O: begin
                                    if (c == "O") n_phase = tclp_pkg::PH_S_COMMA;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_S_COMMA: begin
                                    if (c == tclp_pkg::C_COMMA) n_phase = tclp_pkg::PH_SEQ0_SRV;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_D_I: begin
                                    if (c == "I") n_phase = tclp_pkg::PH_D_A;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_D_A: begin
                                    if (c == "A") n_phase = tclp_pkg::PH_D_G;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_D_G: begin
                                    if (c == "G") n_phase = tclp_pkg::PH_D_COMMA;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_D_COMMA: begin
                                    if (c == tclp_pkg::C_COMMA) n_phase = tclp_pkg::PH_SEQ0_DIAG;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_SEQ0_CMD, tclp_pkg::PH_SEQ0_SRV,
                                tclp_pkg::PH_SEQ0_DIAG: begin
                                    if (digit) begin
                                        n_seq = 32'(d);
                                        unique case (r_phase)
                                            tclp_pkg::PH_SEQ0_CMD:
                                                n_phase = tclp_pkg::PH_SEQ_CMD;
                                            tclp_pkg::PH_SEQ0_SRV:
                                                n_phase = tclp_pkg::PH_SEQ_SRV;
                                            default:
                                                n_phase = tclp_pkg::PH_SEQ_DIAG;
                                        endcase
                                    end else begin
                                        n_err = 1'b1;
                                    end
                                end
                                tclp_pkg::PH_SEQ_CMD, tclp_pkg::PH_SEQ_SRV,
                                tclp_pkg::PH_SEQ_DIAG: begin
                                    if (digit) begin
                                        // reject a number that overflows 32 bits
                                        if (seq_next[35:32] != 4'd0) begin
                                            n_err = 1'b1;
                                        end else begin
                                            n_seq = seq_next[31:0];
                                        end
                                    end else if (c == tclp_pkg::C_COMMA &&
                                                 r_phase == tclp_pkg::PH_SEQ_CMD) begin
                                        n_phase = tclp_pkg::PH_LETTER;
                                    end else if (c == tclp_pkg::C_COMMA &&
                                                 r_phase == tclp_pkg::PH_SEQ_SRV) begin
                                        n_phase = tclp_pkg::PH_CHAN;
                                    end else begin
                                        n_err = 1'b1;
                                    end
                                end
                                tclp_pkg::PH_LETTER: begin
                                    if (dir_hit[4]) begin
                                        n_dir   = dir_hit[3:0];
                                        n_phase = tclp_pkg::PH_CMD_END;
                                    end else begin
                                        n_err = 1'b1;
                                    end
                                end
                                tclp_pkg::PH_CHAN: begin
                                    if (chan_hit[2]) begin
                                        n_chan  = chan_hit[1:0];
                                        n_phase = tclp_pkg::PH_CHAN_COMMA;
                                    end else begin
                                        n_err = 1'b1;
                                    end
                                end
                                tclp_pkg::PH_CHAN_COMMA: begin
                                    if (c == tclp_pkg::C_COMMA) n_phase = tclp_pkg::PH_ANG0;
                                    else n_err = 1'b1;
                                end
                                tclp_pkg::PH_ANG0: begin
                                    if (digit) begin
                                        n_ang   = 9'(d);
                                        n_phase = tclp_pkg::PH_ANG;
                                    end else begin
                                        n_err = 1'b1;
                                    end
                                end
                                tclp_pkg::PH_ANG: begin
                                    if (digit && ang_next <= ang_limit) begin
                                        n_ang = ang_next[8:0];
                                    end else begin
                                        n_err = 1'b1;
                                    end
                                end
                                default: n_err = 1'b1;
                            endcase
                        end
                    end
                end
                default: n_err = r_err;
            endcase
        end
    end

    // Result built from the state at the end of a line
    always_comb begin
        n_res = '0;
        if (i_token.kind == tclp_pkg::TK_LONG) begin
            n_res.frame_kind = tclp_pkg::KIND_LONG;
        end else if (r_err) begin
            n_res.frame_kind = tclp_pkg::KIND_BAD;
        end else begin
            unique case (r_phase)
                tclp_pkg::PH_CMD_END, tclp_pkg::PH_DONE_CMD: begin
                    n_res.frame_kind   = tclp_pkg::KIND_CMD;
                    n_res.seq_number   = r_seq;
                    n_res.command_code = r_dir;
                end
                tclp_pkg::PH_ANG, tclp_pkg::PH_DONE_SRV: begin
                    n_res.frame_kind    = tclp_pkg::KIND_SERVO;
                    n_res.seq_number    = r_seq;
                    n_res.servo_channel = r_chan;
                    n_res.servo_angle   = r_ang;
                end
                tclp_pkg::PH_SEQ_DIAG, tclp_pkg::PH_DONE_DIAG: begin
                    n_res.frame_kind = tclp_pkg::KIND_DIAG;
                    n_res.seq_number = r_seq;
                end
                default: n_res.frame_kind = tclp_pkg::KIND_BAD;
            endcase
        end
    end

    // Parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= tclp_pkg::PH_START;
            r_err   <= 1'b0;
            r_seq   <= '0;
            r_ang   <= '0;
            r_dir   <= '0;
            r_chan  <= '0;
        end else begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_seq   <= n_seq;
            r_ang   <= n_ang;
            r_dir   <= n_dir;
            r_chan  <= n_chan;
        end
    end

    // Output register: load on a line end, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && line_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && line_end) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_res;

    a_line_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && line_end) |=> (r_phase == tclp_pkg::PH_START) && !r_err &&
                                (r_seq == '0))
        else $error("parse state not cleared after line end");

    a_code_only_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.frame_kind != tclp_pkg::KIND_CMD) |->
            (r_res.command_code == '0))
        else $error("command code set on a non-command frame");

    a_angle_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res.frame_kind == tclp_pkg::KIND_SERVO) |->
            ((r_res.servo_channel == tclp_pkg::CHAN_B) ?
                (12'(r_res.servo_angle) <= tclp_pkg::ANGLE_MAX_B) :
                (12'(r_res.servo_angle) <= tclp_pkg::ANGLE_MAX)))
        else $error("servo angle over its limit");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_res.frame_kind == tclp_pkg::KIND_BAD ||
                         r_res.frame_kind == tclp_pkg::KIND_LONG)) |->
            (r_res.seq_number == '0))
        else $error("sequence number on a rejected frame");

endmodule

/* hdl/text_command_line_parser.sv */
// Top level of the text command line parser: framer, token queue, parser.
// Depends on tclp_pkg, tclp_stream_if, tclp_front, tclp_queue and tclp_back.
//
//   channel   direction  payload                                   handshake
//   i_rx      in         rx_byte                                   valid/ready
//   o_res     out        frame_kind, seq_number, command_code,     valid/ready
//                        servo_channel, servo_angle
//
// One byte is taken every cycle while the token queue has room; a newline
// gives one result, loaded into the output register when the parser pops its
// token from the queue and the output register is free.
// A stalled result holds the parser at the next newline token; the queue
// (QUEUE_DEPTH tokens) keeps taking bytes until it fills, then i_rx.ready drops.
// Reset is synchronous and clears framing, queue and parse state.
module text_command_line_parser #(
    parameter int MAX_LINE    = 63,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tclp_stream_if.sink   i_rx,
    tclp_stream_if.source o_res
);
    tclp_pkg::t_token    push_token;
    tclp_pkg::t_token    head_token;
    tclp_pkg::t_q_status q_status;
    logic                push;
    logic                pop;

    tclp_front #(
        .MAX_LINE (MAX_LINE)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_status (q_status),
        .o_push   (push),
        .o_token  (push_token)
    );

    tclp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_token  (push_token),
        .i_pop    (pop),
        .o_token  (head_token),
        .o_status (q_status)
    );

    tclp_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_token  (head_token),
        .i_status (q_status),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule
